>>> rtl/core/smaf_pkg.sv
// shared types, constants and lookup tables for the attention block
// no dependencies; used by the interfaces, the top module, the checker and the testbench
package smaf_pkg;

   localparam int ROW_W     = 6;
   localparam int ELEM_W    = 16;
   localparam int CNT_W     = 7;
   localparam int SCALE_W   = 16;
   localparam int SCORE_W   = 32;
   localparam int LSE_W     = 32;
   localparam int WGT_W     = 17;
   localparam int SUM_W     = 23;
   localparam int OPA_W     = 18;
   localparam int PROD_W    = 34;
   localparam int ACC_W     = 39;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   typedef enum logic [1:0] {
      REQ_KEY   = 2'd0,
      REQ_VALUE = 2'd1,
      REQ_QUERY = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_KEY_COUNT   = 2'd0,
      CSR_QUERY_DIM   = 2'd1,
      CSR_VALUE_DIM   = 2'd2,
      CSR_SCORE_SCALE = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DOT,
      ST_DRAIN,
      ST_SCALE,
      ST_ROUND,
      ST_WT_DIFF,
      ST_WT_EXP,
      ST_WT_SHIFT,
      ST_LN_NORM,
      ST_LN_MUL,
      ST_LN_SUM,
      ST_ACC,
      ST_ACC_DRAIN,
      ST_DIV,
      ST_EMIT
   } state_type;

   // 2^(-i/16), Q1.16
   function automatic logic [WGT_W-1:0] exp_hi(input logic [3:0] idx);
      logic [WGT_W-1:0] r;
      case (idx)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd62757;
         4'd2:    r = 17'd60097;
         4'd3:    r = 17'd57549;
         4'd4:    r = 17'd55109;
         4'd5:    r = 17'd52773;
         4'd6:    r = 17'd50535;
         4'd7:    r = 17'd48393;
         4'd8:    r = 17'd46341;
         4'd9:    r = 17'd44376;
         4'd10:   r = 17'd42495;
         4'd11:   r = 17'd40693;
         4'd12:   r = 17'd38968;
         4'd13:   r = 17'd37316;
         4'd14:   r = 17'd35734;
         4'd15:   r = 17'd34219;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // 2^(-j/256), Q1.16
   function automatic logic [WGT_W-1:0] exp_lo(input logic [3:0] idx);
      logic [WGT_W-1:0] r;
      case (idx)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd65359;
         4'd2:    r = 17'd65182;
         4'd3:    r = 17'd65006;
         4'd4:    r = 17'd64830;
         4'd5:    r = 17'd64655;
         4'd6:    r = 17'd64480;
         4'd7:    r = 17'd64306;
         4'd8:    r = 17'd64132;
         4'd9:    r = 17'd63958;
         4'd10:   r = 17'd63785;
         4'd11:   r = 17'd63613;
         4'd12:   r = 17'd63440;
         4'd13:   r = 17'd63269;
         4'd14:   r = 17'd63098;
         4'd15:   r = 17'd62928;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // log2(1+i/16), Q1.16, i = 0..16
   function automatic logic [WGT_W-1:0] log2_tab(input logic [4:0] idx);
      logic [WGT_W-1:0] r;
      case (idx)
         5'd0:    r = 17'd0;
         5'd1:    r = 17'd5732;
         5'd2:    r = 17'd11136;
         5'd3:    r = 17'd16248;
         5'd4:    r = 17'd21098;
         5'd5:    r = 17'd25711;
         5'd6:    r = 17'd30109;
         5'd7:    r = 17'd34312;
         5'd8:    r = 17'd38336;
         5'd9:    r = 17'd42196;
         5'd10:   r = 17'd45904;
         5'd11:   r = 17'd49472;
         5'd12:   r = 17'd52911;
         5'd13:   r = 17'd56229;
         5'd14:   r = 17'd59434;
         5'd15:   r = 17'd62534;
         5'd16:   r = 17'd65536;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/smaf_if.sv
// valid/ready channel interfaces for the request and response streams
// depends on smaf_pkg for field widths
interface smaf_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          req_type;
   logic [smaf_pkg::ROW_W-1:0]          row;
   logic [smaf_pkg::ROW_W-1:0]          col;
   logic signed [smaf_pkg::ELEM_W-1:0]  value;
   logic                                row_end;

   modport source (output valid, req_type, row, col, value, row_end, input ready);
   modport sink   (input valid, req_type, row, col, value, row_end, output ready);
   modport mon    (input valid, ready, req_type, row, col, value, row_end);
endinterface

interface smaf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [smaf_pkg::ROW_W-1:0]          out_row;
   logic [smaf_pkg::ROW_W-1:0]          out_col;
   logic signed [smaf_pkg::ELEM_W-1:0]  out_value;
   logic signed [smaf_pkg::LSE_W-1:0]   log_sum_exp;
   logic                                last;

   modport source (output valid, out_row, out_col, out_value, log_sum_exp, last, input ready);
   modport sink   (input valid, out_row, out_col, out_value, log_sum_exp, last, output ready);
   modport mon    (input valid, ready, out_row, out_col, out_value, log_sum_exp, last);
endinterface

>>> rtl/core/softmax_attention_forward.sv
// scaled dot-product attention for one head, Q4.12 in and out
// depends on smaf_pkg, smaf_if, smaf_ram, smaf_cell, smaf_div
//
// Usage: key and value elements (req_type key/value) are written into two
// stores, one beat each, accepted in consecutive cycles. Query elements are
// held in a row buffer; the query beat with row_end starts the row compute.
// While a row computes, req.ready stays low; it rises again once the last
// output element of the row has been loaded into the output register.
// A row gives value_dim beats on rsp, each with the row's log-sum-exp.
// Per row_end beat, with kc keys, qd query and vd value elements, the block
// forms kc scores (qd MAC reads, drain, scale, round each), then kc exp
// weights (diff, exp, shift each), then the log (norm, mul, sum), then vd
// outputs (kc MAC steps, drain, serial divide, load into the output register).
// A single MAC is shared by scores and outputs; the chain shifts one cell per
// score or weight written and per MAC step of the outputs. Other beats start no compute.
// When rsp stalls, the finished beat waits in the output register and the
// next column waits for it. Configuration goes through the APB-style port,
// with pready always high; write it only while the block is idle.
// Reset (synchronous) clears the control state and the configuration to
// 64 keys, 64 query and value elements and a scale of 8192; the stores
// keep their contents and hold no valid data until written.
module softmax_attention_forward #(
   parameter int MAX_SEQ = 64,
   parameter int MAX_DIM = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   smaf_req_if.sink                     req,
   smaf_rsp_if.source                   rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [smaf_pkg::CSR_AW-1:0]  paddr,
   input  logic [smaf_pkg::CSR_DW-1:0]  pwdata,
   output logic [smaf_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready
);
   import smaf_pkg::*;

   localparam int KEY_LIMIT = (MAX_SEQ < 64) ? MAX_SEQ : 64;
   localparam int STORE_D   = MAX_SEQ * MAX_DIM;
   localparam int SA_W      = (STORE_D > 1) ? $clog2(STORE_D) : 1;
   localparam int QA_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   // configuration
   logic [CNT_W-1:0]   key_count_ff, query_dim_ff, value_dim_ff;
   logic [SCALE_W-1:0] score_scale_ff;
   logic               csr_wr;
   csr_index_type      csr_idx;
   logic [CNT_W-1:0]   kc, qd, vd;

   // control
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   d_ff, d_in;
   logic [SA_W-1:0]    base_ff, base_in;
   logic [ROW_W-1:0]   qrow_ff, qrow_in;

   // mac pipeline
   logic               rd_vld_ff, rd_vld_in;
   logic               prod_vld_ff;
   logic signed [OPA_W-1:0]  wq_ff, wq_in;
   logic signed [OPA_W-1:0]  opa;
   logic signed [ELEM_W-1:0] opb;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic               acc_clr;
   logic               out_phase;

   // score, weight and log datapath
   logic [34:0]        sc_hi_ff, sc_lo_ff;
   logic               sgn_ff, sgn_in;
   logic [37:0]        acc_mag38;
   logic [53:0]        full_prod;
   logic [53:0]        rnd_prod;
   logic [29:0]        rnd_mag;
   logic signed [SCORE_W-1:0] score;
   logic signed [SCORE_W-1:0] mx_ff, mx_in;
   logic [32:0]        dif;
   logic [49:0]        t_prod;
   logic [33:0]        t_ff;
   logic [33:0]        m_prod;
   logic [WGT_W-1:0]   m_ff;
   logic [4:0]         n_ff;
   logic               nbig_ff;
   logic [WGT_W-1:0]   wgt;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [2:0]         e_sel;
   logic [28:0]        xs;
   logic [3:0]         l_idx;
   logic [17:0]        l_rem;
   logic [WGT_W-1:0]   l_lo, l_hi, l_dif;
   logic [34:0]        l_prod;
   logic [WGT_W-1:0]   l_ff;
   logic [2:0]         e3_ff;
   logic [18:0]        lg;
   logic [34:0]        ln_prod;
   logic [18:0]        ln_ff;
   logic signed [33:0] lse_sum;
   logic signed [LSE_W-1:0] lse_ff, lse_in;

   // chain
   logic               chain_shift;
   logic [SCORE_W-1:0] chain_feed;
   logic [SCORE_W-1:0] chain_val [KEY_LIMIT];
   logic [SCORE_W-1:0] head;

   // stores
   logic               acc_beat;
   logic               in_store;
   logic               key_we, val_we, q_we;
   logic [SA_W-1:0]    st_waddr;
   logic [SA_W-1:0]    st_raddr;
   logic [ELEM_W-1:0]  k_rd, v_rd, q_rd;

   // divider and output
   logic               div_start;
   logic [ACC_W-1:0]   div_num;
   logic [ACC_W-1:0]   acc_mag;
   logic               div_done;
   logic [ACC_W-1:0]   div_quo;
   logic [ELEM_W-1:0]  sat_val;
   logic               out_load;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]   out_row_ff, out_col_ff;
   logic [ELEM_W-1:0]  out_value_ff;
   logic signed [LSE_W-1:0] out_lse_ff;
   logic               out_last_ff;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = csr_index_type'(paddr[3:2]);

   always_comb begin
      case (csr_idx)
         CSR_KEY_COUNT:   prdata = CSR_DW'(key_count_ff);
         CSR_QUERY_DIM:   prdata = CSR_DW'(query_dim_ff);
         CSR_VALUE_DIM:   prdata = CSR_DW'(value_dim_ff);
         CSR_SCORE_SCALE: prdata = CSR_DW'(score_scale_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff   <= 7'd64;
         query_dim_ff   <= 7'd64;
         value_dim_ff   <= 7'd64;
         score_scale_ff <= 16'd8192;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_KEY_COUNT:   key_count_ff   <= pwdata[CNT_W-1:0];
            CSR_QUERY_DIM:   query_dim_ff   <= pwdata[CNT_W-1:0];
            CSR_VALUE_DIM:   value_dim_ff   <= pwdata[CNT_W-1:0];
            CSR_SCORE_SCALE: score_scale_ff <= pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp counts to the supported ranges
   assign kc = (key_count_ff == '0) ? CNT_W'(1) :
               (key_count_ff > CNT_W'(KEY_LIMIT)) ? CNT_W'(KEY_LIMIT) : key_count_ff;
   assign qd = (query_dim_ff == '0) ? CNT_W'(1) :
               (query_dim_ff > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : query_dim_ff;
   assign vd = (value_dim_ff == '0) ? CNT_W'(1) :
               (value_dim_ff > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : value_dim_ff;

   // ---------------- stores ----------------
   assign req.ready = (state_ff == ST_IDLE);
   assign acc_beat  = req.valid & req.ready;
   assign in_store  = (32'(req.row) < MAX_SEQ) && (32'(req.col) < MAX_DIM);
   assign st_waddr  = SA_W'(32'(req.row) * MAX_DIM + 32'(req.col));
   assign key_we    = acc_beat && (req.req_type == REQ_KEY) && in_store;
   assign val_we    = acc_beat && (req.req_type == REQ_VALUE) && in_store;
   assign q_we      = acc_beat && (req.req_type == REQ_QUERY) && (32'(req.col) < MAX_DIM);
   assign st_raddr  = out_phase ? base_ff : base_ff + SA_W'(d_ff);

   smaf_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_D)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (st_waddr),
      .wr_data (req.value),
      .rd_addr (st_raddr),
      .rd_data (k_rd)
   );

   smaf_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_D)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (st_waddr),
      .wr_data (req.value),
      .rd_addr (st_raddr),
      .rd_data (v_rd)
   );

   smaf_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIM)) u_query_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (QA_W'(req.col)),
      .wr_data (req.value),
      .rd_addr (d_ff[QA_W-1:0]),
      .rd_data (q_rd)
   );

   // ---------------- score / weight chain ----------------
   for (genvar i = 0; i < KEY_LIMIT; i++) begin : g_chain
      logic [SCORE_W-1:0] nxt;
      logic               is_tail;
      if (i == KEY_LIMIT - 1) begin : g_end
         assign nxt = chain_feed;
      end else begin : g_mid
         assign nxt = chain_val[i+1];
      end
      assign is_tail = ((kc - CNT_W'(1)) == CNT_W'(i));
      smaf_cell #(.WIDTH(SCORE_W)) u_cell (
         .clock    (clock),
         .shift    (chain_shift),
         .tail     (is_tail),
         .feed     (chain_feed),
         .next_val (nxt),
         .val      (chain_val[i])
      );
   end
   assign head = chain_val[0];

   // ---------------- shared mac ----------------
   assign out_phase = (state_ff == ST_ACC) || (state_ff == ST_ACC_DRAIN);
   assign opa = out_phase ? wq_ff : OPA_W'(signed'(q_rd));
   assign opb = out_phase ? signed'(v_rd) : signed'(k_rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= rd_vld_ff;
      end
      prod_ff <= opa * opb;
      wq_ff   <= wq_in;
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // ---------------- score scaling ----------------
   assign acc_mag   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign acc_mag38 = acc_mag[37:0];
   assign full_prod = {sc_hi_ff, 19'b0} + 54'(sc_lo_ff);
   assign rnd_prod  = full_prod + 54'(1 << 23);
   assign rnd_mag   = rnd_prod[53:24];
   assign score     = sgn_ff ? -SCORE_W'(signed'({2'b00, rnd_mag}))
                             : SCORE_W'(signed'({2'b00, rnd_mag}));

   // ---------------- exp weight ----------------
   assign dif    = 33'(SCORE_W'(mx_ff) - SCORE_W'(signed'(head)));
   assign t_prod = dif * 17'd94548;
   assign m_prod = exp_hi(t_ff[15:12]) * exp_lo(t_ff[11:8]) + 34'd32768;
   assign wgt    = nbig_ff ? '0 : (m_ff >> n_ff);

   // ---------------- log of the weight sum ----------------
   always_comb begin
      e_sel = 3'd0;
      for (int b = 17; b <= 22; b++) begin
         if (sum_ff[b]) begin
            e_sel = 3'(b - 16);
         end
      end
   end
   assign xs      = 29'(sum_ff) << (3'd6 - e_sel);
   assign l_idx   = xs[21:18];
   assign l_rem   = xs[17:0];
   assign l_lo    = log2_tab({1'b0, l_idx});
   assign l_hi    = log2_tab(5'({1'b0, l_idx}) + 5'd1);
   assign l_dif   = l_hi - l_lo;
   assign l_prod  = l_dif * l_rem;
   assign lg      = {e3_ff, 16'b0} + 19'(l_ff);
   assign ln_prod = lg * 16'd45426 + 35'd32768;
   assign lse_sum = 34'(mx_ff) + signed'(34'(ln_ff));

   always_ff @(posedge clock) begin
      sc_hi_ff <= acc_mag38[37:19] * score_scale_ff;
      sc_lo_ff <= acc_mag38[18:0] * score_scale_ff;
      t_ff     <= t_prod[49:16];
      m_ff     <= m_prod[32:16];
      n_ff     <= t_ff[20:16];
      nbig_ff  <= (t_ff[33:16] >= 18'd17);
      l_ff     <= l_lo + l_prod[34:18];
      e3_ff    <= e_sel;
      ln_ff    <= ln_prod[34:16];
   end

   // ---------------- divider ----------------
   assign div_num = acc_mag + ACC_W'(sum_ff >> 1);

   smaf_div #(.NUM_W(ACC_W), .DEN_W(SUM_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (sum_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      if (sgn_ff) begin
         sat_val = (div_quo > ACC_W'(32768)) ? 16'h8000 : (~div_quo[15:0] + 16'd1);
      end else begin
         sat_val = (div_quo > ACC_W'(32767)) ? 16'h7fff : div_quo[15:0];
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      d_in         = d_ff;
      base_in      = base_ff;
      qrow_in      = qrow_ff;
      rd_vld_in    = 1'b0;
      wq_in        = wq_ff;
      acc_clr      = 1'b0;
      sgn_in       = sgn_ff;
      mx_in        = mx_ff;
      sum_in       = sum_ff;
      lse_in       = lse_ff;
      chain_shift  = 1'b0;
      chain_feed   = head;
      div_start    = 1'b0;
      out_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (acc_beat && (req.req_type == REQ_QUERY) && req.row_end) begin
               qrow_in  = req.row;
               k_in     = '0;
               d_in     = '0;
               base_in  = '0;
               acc_clr  = 1'b1;
               state_in = ST_DOT;
            end
         end
         ST_DOT: begin
            rd_vld_in = 1'b1;
            d_in      = d_ff + CNT_W'(1);
            if (d_ff + CNT_W'(1) == qd) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               sgn_in   = acc_ff[ACC_W-1];
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            chain_shift = 1'b1;
            chain_feed  = score;
            if (k_ff == '0 || score > mx_ff) begin
               mx_in = score;
            end
            acc_clr = 1'b1;
            d_in    = '0;
            if (k_ff + CNT_W'(1) == kc) begin
               k_in     = '0;
               sum_in   = '0;
               state_in = ST_WT_DIFF;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               base_in  = base_ff + SA_W'(MAX_DIM);
               state_in = ST_DOT;
            end
         end
         ST_WT_DIFF: begin
            state_in = ST_WT_EXP;
         end
         ST_WT_EXP: begin
            state_in = ST_WT_SHIFT;
         end
         ST_WT_SHIFT: begin
            chain_shift = 1'b1;
            chain_feed  = SCORE_W'(wgt);
            sum_in      = sum_ff + SUM_W'(wgt);
            if (k_ff + CNT_W'(1) == kc) begin
               k_in     = '0;
               state_in = ST_LN_NORM;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               state_in = ST_WT_DIFF;
            end
         end
         ST_LN_NORM: begin
            state_in = ST_LN_MUL;
         end
         ST_LN_MUL: begin
            state_in = ST_LN_SUM;
         end
         ST_LN_SUM: begin
            if (lse_sum > 34'sh07fffffff) begin
               lse_in = 32'sh7fffffff;
            end else if (lse_sum < -34'sh080000000) begin
               lse_in = 32'sh80000000;
            end else begin
               lse_in = lse_sum[31:0];
            end
            k_in     = '0;
            d_in     = '0;
            base_in  = '0;
            acc_clr  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // one weight per beat from the chain head, rotated back to the tail
            rd_vld_in   = 1'b1;
            wq_in       = signed'({1'b0, head[WGT_W-1:0]});
            chain_shift = 1'b1;
            base_in     = base_ff + SA_W'(MAX_DIM);
            if (k_ff + CNT_W'(1) == kc) begin
               k_in     = '0;
               state_in = ST_ACC_DRAIN;
            end else begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         ST_ACC_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               sgn_in    = acc_ff[ACC_W-1];
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_load = 1'b1;
               if (d_ff + CNT_W'(1) == vd) begin
                  state_in = ST_IDLE;
               end else begin
                  d_in     = d_ff + CNT_W'(1);
                  base_in  = SA_W'(d_ff + CNT_W'(1));
                  acc_clr  = 1'b1;
                  state_in = ST_ACC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         d_ff         <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         d_ff         <= d_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      qrow_ff <= qrow_in;
      sgn_ff  <= sgn_in;
      mx_ff   <= mx_in;
      sum_ff  <= sum_in;
      lse_ff  <= lse_in;
      if (out_load) begin
         out_row_ff   <= qrow_ff;
         out_col_ff   <= d_ff[ROW_W-1:0];
         out_value_ff <= sat_val;
         out_lse_ff   <= lse_ff;
         out_last_ff  <= (d_ff + CNT_W'(1) == vd);
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_row     = out_row_ff;
   assign rsp.out_col     = out_col_ff;
   assign rsp.out_value   = signed'(out_value_ff);
   assign rsp.log_sum_exp = out_lse_ff;
   assign rsp.last        = out_last_ff;
endmodule

>>> rtl/core/smaf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module smaf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/smaf_cell.sv
// one cell of the score/weight chain: holds one entry, takes its neighbor's
// entry on a shift, or the feed value when it is the current tail
module smaf_cell #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             shift,
   input  logic             tail,
   input  logic [WIDTH-1:0] feed,
   input  logic [WIDTH-1:0] next_val,
   output logic [WIDTH-1:0] val
);
   logic [WIDTH-1:0] val_ff;
   logic [WIDTH-1:0] val_in;

   always_comb begin
      val_in = val_ff;
      if (shift) begin
         val_in = tail ? feed : next_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;
endmodule

>>> rtl/core/smaf_div.sv
// restoring unsigned divider, one quotient bit per cycle
// no dependencies
module smaf_div #(
   parameter int NUM_W = 39,
   parameter int DEN_W = 23
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      if (start) begin
         quo_in = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CW'(NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

>>> rtl/core/smaf_checker.sv
// port-level checks for softmax_attention_forward, attached by bind
// depends on smaf_pkg
module smaf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [1:0]                   req_kind,
   input logic                         req_row_end,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [smaf_pkg::ROW_W-1:0]   rsp_out_col,
   input logic [smaf_pkg::ELEM_W-1:0]  rsp_out_value,
   input logic                         rsp_last
);
   import smaf_pkg::*;

   // output register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_col) && $stable(rsp_out_value) && $stable(rsp_last))
      else $error("stalled rsp beat changed");

   // more beats of the row remain, so no new request is taken
   a_busy_midrow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request accepted in the middle of a row");

   // a row end starts the compute
   a_row_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == REQ_QUERY) && req_row_end |=> !req_ready)
      else $error("row end did not start compute");
endmodule

bind softmax_attention_forward smaf_checker u_smaf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_kind      (req.req_type),
   .req_row_end   (req.row_end),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_out_col   (rsp.out_col),
   .rsp_out_value (rsp.out_value),
   .rsp_last      (rsp.last)
);

>>> test/tb_softmax_attention_forward.sv
// self-checking testbench for softmax_attention_forward: loads keys and values,
// streams query rows and checks every output beat against an in-bench predictor
// depends on smaf_pkg, smaf_if and the attention rtl
`timescale 1ns / 100ps

module tb_softmax_attention_forward;
   import smaf_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int SEQ = 64;
   localparam int DIM = 64;

   typedef struct {
      logic [ROW_W-1:0]         row;
      logic [ROW_W-1:0]         col;
      logic signed [ELEM_W-1:0] value;
      logic signed [LSE_W-1:0]  lse;
      logic                     last;
   } attn_beat_t;

   class attn_scoreboard;
      logic [15:0] keys [SEQ*DIM];
      logic [15:0] vals [SEQ*DIM];
      logic [15:0] qrow [DIM];
      int unsigned n_keys, q_dim, v_dim, scale;
      attn_beat_t  pending [$];
      int          errors;
      int          checked;

      function new();
         n_keys = 64;
         q_dim  = 64;
         v_dim  = 64;
         scale  = 8192;
      endfunction

      function int unsigned clamp(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         return (v > hi) ? hi : v;
      endfunction

      function void set_reg(csr_index_type idx, int unsigned v);
         case (idx)
            CSR_KEY_COUNT:   n_keys = v & 32'h7f;
            CSR_QUERY_DIM:   q_dim  = v & 32'h7f;
            CSR_VALUE_DIM:   v_dim  = v & 32'h7f;
            CSR_SCORE_SCALE: scale  = v & 32'hffff;
            default: ;
         endcase
      endfunction

      function longint unsigned exp_weight(longint unsigned d);
         longint unsigned t, n, m;
         int unsigned     f;
         t = (d * 94548) >> 16;
         n = t >> 16;
         f = 32'(t & 16'hffff);
         m = (longint'(exp_hi(f[15:12])) * exp_lo(f[11:8]) + 32768) >> 16;
         if (n >= 17) return 0;
         return m >> n;
      endfunction

      function longint ln_fixed(longint unsigned s);
         int unsigned     e, idx;
         longint unsigned x, rem, l, lg, a, b;
         e = 16;
         while (e < 22 && (s >> (e + 1)) != 0) e++;
         x   = (s << (22 - e)) & 22'h3fffff;
         idx = 32'(x >> 18);
         rem = x & 18'h3ffff;
         a   = log2_tab(idx[4:0]);
         b   = log2_tab(idx[4:0] + 5'd1);
         l   = a + (((b - a) * rem) >> 18);
         lg  = (longint'(e - 16) << 16) + l;
         return (lg * 45426 + 32768) >> 16;
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // one accepted request beat; a query beat with row_end queues a whole row
      function void note(logic [1:0] kind, logic [5:0] row, logic [5:0] col,
                         logic [15:0] value, logic row_end);
         int unsigned     kc, qd, vd;
         longint          dot, p, mx, acc, o, lse;
         longint unsigned mag, sum, q;
         longint          score [SEQ];
         longint unsigned wgt [SEQ];
         attn_beat_t      b;
         if (kind == REQ_KEY) begin
            keys[row*DIM+col] = value;
            return;
         end
         if (kind == REQ_VALUE) begin
            vals[row*DIM+col] = value;
            return;
         end
         if (kind != REQ_QUERY) return;
         qrow[col] = value;
         if (!row_end) return;
         kc = clamp(n_keys, SEQ);
         qd = clamp(q_dim, DIM);
         vd = clamp(v_dim, DIM);
         for (int k = 0; k < kc; k++) begin
            dot = 0;
            for (int d = 0; d < qd; d++)
               dot += longint'($signed(qrow[d])) * longint'($signed(keys[k*DIM+d]));
            p   = dot * longint'(scale);
            mag = (p < 0) ? -p : p;
            mag = (mag + (64'd1 << 23)) >> 24;
            score[k] = sat32((p < 0) ? -longint'(mag) : longint'(mag));
         end
         mx = score[0];
         for (int k = 1; k < kc; k++) if (score[k] > mx) mx = score[k];
         sum = 0;
         for (int k = 0; k < kc; k++) begin
            wgt[k] = exp_weight(mx - score[k]);
            sum += wgt[k];
         end
         lse = sat32(mx + ln_fixed(sum));
         for (int d = 0; d < vd; d++) begin
            acc = 0;
            for (int k = 0; k < kc; k++)
               acc += longint'(wgt[k]) * longint'($signed(vals[k*DIM+d]));
            mag = (acc < 0) ? -acc : acc;
            q   = (mag + sum / 2) / sum;
            o   = (acc < 0) ? -longint'(q) : longint'(q);
            if (o > 32767) o = 32767;
            if (o < -32768) o = -32768;
            b.row   = row;
            b.col   = 6'(d);
            b.value = 16'(o);
            b.lse   = 32'(lse);
            b.last  = (d == vd - 1);
            pending.push_back(b);
         end
      endfunction

      task report(string what);
         errors++;
         $display("%0t mismatch: %s", $time, what);
      endtask

      task check(attn_beat_t got);
         attn_beat_t want;
         checked++;
         if (pending.size() == 0) begin
            report($sformatf("unexpected beat row %0d col %0d", got.row, got.col));
            return;
         end
         want = pending.pop_front();
         if (got.row !== want.row)
            report($sformatf("out_row %0d, want %0d", got.row, want.row));
         if (got.col !== want.col)
            report($sformatf("out_col %0d, want %0d", got.col, want.col));
         if (got.value !== want.value)
            report($sformatf("row %0d col %0d out_value %0d, want %0d",
                             want.row, want.col, got.value, want.value));
         if (got.lse !== want.lse)
            report($sformatf("row %0d log_sum_exp %0d, want %0d",
                             want.row, got.lse, want.lse));
         if (got.last !== want.last)
            report($sformatf("row %0d col %0d last %0b", want.row, want.col, got.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   smaf_req_if req ();
   smaf_rsp_if rsp ();

   softmax_attention_forward i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #4 clock = ~clock;

   attn_scoreboard sb = new();

   bit key_seen [SEQ*DIM];
   bit val_seen [SEQ*DIM];
   bit q_seen [DIM];
   bit quiet = 0;
   bit hold_go = 0;
   bit hold_done = 0;
   int hold_cnt = 0;
   int items = 0;
   int rows_done = 0;

   initial begin
      req.valid    = 1'b0;
      req.req_type = REQ_KEY;
      req.row      = '0;
      req.col      = '0;
      req.value    = '0;
      req.row_end  = 1'b0;
      rsp.ready    = 1'b0;
   end

   // result side: random stalls, one long hold-off to back the block up
   always @(posedge clock) begin
      attn_beat_t got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.row   = rsp.out_row;
         got.col   = rsp.out_col;
         got.value = rsp.out_value;
         got.lse   = rsp.log_sum_exp;
         got.last  = rsp.last;
         sb.check(got);
      end
      if (hold_go && !hold_done && hold_cnt == 0) begin
         hold_cnt  <= 600;
         hold_done <= 1;
         rsp.ready <= 1'b0;
      end else if (hold_cnt > 1) begin
         hold_cnt  <= hold_cnt - 1;
         rsp.ready <= 1'b0;
      end else begin
         hold_cnt  <= 0;
         rsp.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 17);
      end
   end

   task send(logic [1:0] kind, logic [5:0] row, logic [5:0] col,
             logic [15:0] value, logic row_end);
      if (!quiet && $urandom_range(99) < 17) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.req_type <= kind;
      req.row      <= row;
      req.col      <= col;
      req.value    <= value;
      req.row_end  <= row_end;
      do @(posedge clock); while (!req.ready);
      sb.note(kind, row, col, value, row_end);
      items++;
   endtask

   task pause;
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   function logic [15:0] pick_elem();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task write_reg(csr_index_type idx, int unsigned v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'(idx) << 2;
      pwdata  <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(idx, v);
   endtask

   // wait for every queued beat, then let the block settle before a register write
   task drain;
      pause();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task noise;
      case ($urandom_range(2))
         0: send(REQ_UNUSED, 6'($urandom), 6'($urandom), 16'($urandom), 1'($urandom));
         1: begin
            int r, c;
            r = $urandom_range(SEQ - 1);
            c = $urandom_range(DIM - 1);
            key_seen[r*DIM+c] = 1;
            send(REQ_KEY, 6'(r), 6'(c), pick_elem(), 1'b1);
         end
         default: begin
            int r, c;
            r = $urandom_range(SEQ - 1);
            c = $urandom_range(DIM - 1);
            val_seen[r*DIM+c] = 1;
            send(REQ_VALUE, 6'(r), 6'(c), pick_elem(), 1'b1);
         end
      endcase
   endtask

   // configure, fill whatever the rows will read, then stream query rows
   task run_phase(int unsigned kc_raw, int unsigned qd_raw, int unsigned vd_raw,
                  int unsigned scl, int n_rows);
      int kc, qd, vd, c;
      drain();
      write_reg(CSR_KEY_COUNT, kc_raw);
      write_reg(CSR_QUERY_DIM, qd_raw);
      write_reg(CSR_VALUE_DIM, vd_raw);
      write_reg(CSR_SCORE_SCALE, scl);
      kc = sb.clamp(kc_raw & 32'h7f, SEQ);
      qd = sb.clamp(qd_raw & 32'h7f, DIM);
      vd = sb.clamp(vd_raw & 32'h7f, DIM);
      for (int r = 0; r < kc; r++) begin
         for (int d = 0; d < qd; d++)
            if (!key_seen[r*DIM+d] || $urandom_range(9) < 6) begin
               key_seen[r*DIM+d] = 1;
               send(REQ_KEY, 6'(r), 6'(d), pick_elem(), 1'b0);
            end
         for (int d = 0; d < vd; d++)
            if (!val_seen[r*DIM+d] || $urandom_range(9) < 6) begin
               val_seen[r*DIM+d] = 1;
               send(REQ_VALUE, 6'(r), 6'(d), pick_elem(), 1'b0);
            end
         if ($urandom_range(9) == 0) noise();
      end
      // the long hold-off starts while query beats keep coming
      if (rows_done == 2) hold_go = 1;
      for (int n = 0; n < n_rows; n++) begin
         logic [5:0] qr;
         qr = 6'($urandom);
         for (int d = 0; d < qd; d++)
            if (!q_seen[d] || $urandom_range(9) < 7) begin
               q_seen[d] = 1;
               send(REQ_QUERY, qr, 6'(d), pick_elem(), 1'b0);
            end
         if ($urandom_range(7) == 0) noise();
         // the closing beat may land on any column, in use or not
         c = ($urandom_range(3) == 0) ? $urandom_range(DIM - 1) : $urandom_range(qd - 1);
         q_seen[c] = 1;
         send(REQ_QUERY, qr, 6'(c), pick_elem(), 1'b1);
         rows_done++;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register extremes, out-of-range values clamp
      run_phase(127, 1, 1, 65535, 2);
      run_phase(1, 2, 127, 0, 3);
      run_phase(0, 0, 0, 1, 2);
      run_phase(4, 5, 6, 8192, 2);

      while (items < 360) begin
         quiet = (rows_done < 12);
         run_phase($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                   $urandom_range(1, 3) == 1 ? 16'hffff : $urandom, $urandom_range(2, 6));
      end
      quiet = 0;
      pause();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("run covered %0d request beats, %0d query rows and %0d output beats",
               items, rows_done, sb.checked);
      if (sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout with %0d output beats outstanding", sb.pending.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
